/* sv/ra_pkg.sv */
package ra_pkg;

  // operation codes
  typedef enum logic [4:0] {
    OP_ADD    = 5'd0,
    OP_SUB    = 5'd1,
    OP_AND    = 5'd2,
    OP_OR     = 5'd3,
    OP_XOR    = 5'd4,
    OP_SLL    = 5'd5,
    OP_SRL    = 5'd6,
    OP_SRA    = 5'd7,
    OP_SLT    = 5'd8,
    OP_SLTU   = 5'd9,
    OP_MUL    = 5'd10,
    OP_MULH   = 5'd11,
    OP_MULHSU = 5'd12,
    OP_MULHU  = 5'd13,
    OP_DIV    = 5'd14,
    OP_DIVU   = 5'd15,
    OP_REM    = 5'd16,
    OP_REMU   = 5'd17
  } op_e;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned DIV_STEPS = XLEN;
  localparam int unsigned MUL_LAT   = 2;

  typedef struct packed {
    logic [4:0]      mode;
    logic [XLEN-1:0] operand_a;
    logic [XLEN-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic [XLEN-1:0] result;
    logic            bad_op;
  } out_t;

  // divider working state: partial remainder, dividend shifting into quotient, divisor
  typedef struct packed {
    logic [XLEN-1:0] rem;
    logic [XLEN-1:0] quo;
    logic [XLEN-1:0] dsr;
  } div_t;

  // control travelling alongside the divider stages
  typedef struct packed {
    logic            vld;
    op_e             op;
    logic            bad;
    logic [XLEN-1:0] res;
    logic            neg_q;
    logic            neg_r;
  } side_t;

endpackage

/* sv/rv32im_alu.sv */
// RV32IM integer ALU. Pulse start_i with an operation code and two operands; one
// beat is taken every cycle and busy_o never rises. Each result appears on out_o for
// a single cycle with done_o high, in issue order. The divider resolves one quotient
// bit per pipeline stage over 32 stages; every operation's control travels through
// those stages, and the multiplier result is delayed to match. Unknown codes give
// bad_op with a zero result. The receiver cannot stall the result.
module rv32im_alu (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  ra_pkg::in_t  in_i,
  output logic         busy_o,
  output logic         done_o,
  output ra_pkg::out_t out_o
);
  import ra_pkg::*;

  op_e             op;
  logic            bad;
  logic [XLEN-1:0] a, b;
  logic [4:0]      sh;
  logic [XLEN-1:0] simple;
  logic            sgn_div;
  div_t            div_d;
  side_t           side_d;
  logic [XLEN:0]   ma_d, mb_d, ma_q, mb_q;
  logic            mhi_d, mhi_q;

  div_t            div_w  [0:DIV_STEPS];
  side_t           side_w [0:DIV_STEPS];
  logic [XLEN-1:0] mul_w;
  logic [XLEN-1:0] mul_dly_q [0:DIV_STEPS-MUL_LAT-1];

  logic [XLEN-1:0] res_d;
  out_t            out_q;
  logic            done_q;

  assign busy_o = 1'b0;

  // decode and the simple (non-multiply, non-divide) operations
  always_comb begin
    op  = op_e'(in_i.mode);
    a   = in_i.operand_a;
    b   = in_i.operand_b;
    sh  = b[4:0];
    bad = 1'b0;
    simple = '0;
    case (op)
      OP_ADD:  simple = a + b;
      OP_SUB:  simple = a - b;
      OP_AND:  simple = a & b;
      OP_OR:   simple = a | b;
      OP_XOR:  simple = a ^ b;
      OP_SLL:  simple = a << sh;
      OP_SRL:  simple = a >> sh;
      OP_SRA:  simple = XLEN'($signed(a) >>> sh);
      OP_SLT:  simple = {{(XLEN-1){1'b0}}, $signed(a) < $signed(b)};
      OP_SLTU: simple = {{(XLEN-1){1'b0}}, a < b};
      OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU,
      OP_DIV, OP_DIVU, OP_REM, OP_REMU: simple = '0;
      default: bad = 1'b1;
    endcase

    // divider set-up on magnitudes
    sgn_div      = (op == OP_DIV) || (op == OP_REM);
    div_d.rem    = '0;
    div_d.quo    = (sgn_div && a[XLEN-1]) ? XLEN'(-a) : a;
    div_d.dsr    = (sgn_div && b[XLEN-1]) ? XLEN'(-b) : b;
    side_d.vld   = start_i;
    side_d.op    = op;
    side_d.bad   = bad;
    side_d.res   = simple;
    side_d.neg_q = sgn_div && (a[XLEN-1] ^ b[XLEN-1]) && (b != '0);
    side_d.neg_r = sgn_div && a[XLEN-1];

    // multiplier operand extension
    ma_d  = {(op == OP_MULH || op == OP_MULHSU) && a[XLEN-1], a};
    mb_d  = {(op == OP_MULH) && b[XLEN-1], b};
    mhi_d = (op != OP_MUL);
  end

  // input register
  always_ff @(posedge clk_i) begin
    div_w[0] <= div_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    mhi_q <= mhi_d;
  end

  // input control with its valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_w[0] <= '0;
    end else begin
      side_w[0] <= side_d;
    end
  end

  // divider pipeline, one quotient bit per stage
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    ra_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .div_i  (div_w[i]),
      .side_i (side_w[i]),
      .div_o  (div_w[i+1]),
      .side_o (side_w[i+1])
    );
  end

  // multiplier and its alignment delay
  ra_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (ma_q),
    .b_i    (mb_q),
    .hi_i   (mhi_q),
    .prod_o (mul_w)
  );

  always_ff @(posedge clk_i) begin
    mul_dly_q[0] <= mul_w;
    for (int i = 1; i < DIV_STEPS - MUL_LAT; i++) begin
      mul_dly_q[i] <= mul_dly_q[i-1];
    end
  end

  // final selection and sign fix-up
  always_comb begin
    case (side_w[DIV_STEPS].op)
      OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU:
        res_d = mul_dly_q[DIV_STEPS-MUL_LAT-1];
      OP_DIV, OP_DIVU:
        res_d = side_w[DIV_STEPS].neg_q ? XLEN'(-div_w[DIV_STEPS].quo)
                                        : div_w[DIV_STEPS].quo;
      OP_REM, OP_REMU:
        res_d = side_w[DIV_STEPS].neg_r ? XLEN'(-div_w[DIV_STEPS].rem)
                                        : div_w[DIV_STEPS].rem;
      default:
        res_d = side_w[DIV_STEPS].res;
    endcase
    if (side_w[DIV_STEPS].bad) begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.result <= res_d;
    out_q.bad_op <= side_w[DIV_STEPS].bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= side_w[DIV_STEPS].vld;
    end
  end

  assign done_o = done_q;
  assign out_o  = out_q;

endmodule

/* sv/ra_div_stage.sv */
module ra_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ra_pkg::div_t  div_i,
  input  ra_pkg::side_t side_i,
  output ra_pkg::div_t  div_o,
  output ra_pkg::side_t side_o
);
  import ra_pkg::*;

  logic [XLEN:0]   trial;
  logic            ge;
  div_t            div_d, div_q;
  side_t           side_q;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial = {div_i.rem, div_i.quo[XLEN-1]};
    ge    = trial >= {1'b0, div_i.dsr};
    div_d.dsr = div_i.dsr;
    div_d.quo = {div_i.quo[XLEN-2:0], ge};
    if (ge) begin
      div_d.rem = XLEN'(trial - {1'b0, div_i.dsr});
    end else begin
      div_d.rem = trial[XLEN-1:0];
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  // control with its valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else begin
      side_q <= side_i;
    end
  end

  assign div_o  = div_q;
  assign side_o = side_q;

endmodule

/* sv/ra_mul.sv */
module ra_mul (
  input  logic                    clk_i,
  input  logic [ra_pkg::XLEN:0]   a_i,
  input  logic [ra_pkg::XLEN:0]   b_i,
  input  logic                    hi_i,
  output logic [ra_pkg::XLEN-1:0] prod_o
);
  import ra_pkg::*;

  localparam int unsigned H = XLEN / 2;

  logic signed [2*H+1:0] pp_ll_d, pp_lh_d, pp_hl_d, pp_hh_d;
  logic signed [2*H+1:0] pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic                  hi_q;
  logic signed [2*XLEN+1:0] sum;
  logic [XLEN-1:0]       prod_q;

  // first stage: four partial products of 17x17 bits
  always_comb begin
    pp_ll_d = $signed({1'b0, a_i[H-1:0]})  * $signed({1'b0, b_i[H-1:0]});
    pp_lh_d = $signed({1'b0, a_i[H-1:0]})  * $signed(b_i[XLEN:H]);
    pp_hl_d = $signed(a_i[XLEN:H])         * $signed({1'b0, b_i[H-1:0]});
    pp_hh_d = $signed(a_i[XLEN:H])         * $signed(b_i[XLEN:H]);
  end

  always_ff @(posedge clk_i) begin
    pp_ll_q <= pp_ll_d;
    pp_lh_q <= pp_lh_d;
    pp_hl_q <= pp_hl_d;
    pp_hh_q <= pp_hh_d;
    hi_q    <= hi_i;
  end

  // second stage: align and add, pick the wanted half
  always_comb begin
    sum = (2*XLEN+2)'(pp_ll_q)
        + ((2*XLEN+2)'(pp_lh_q) <<< H)
        + ((2*XLEN+2)'(pp_hl_q) <<< H)
        + ((2*XLEN+2)'(pp_hh_q) <<< XLEN);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= hi_q ? sum[2*XLEN-1:XLEN] : sum[XLEN-1:0];
  end

  assign prod_o = prod_q;

endmodule
